>>> rtl/core/hftw_pkg.sv
// Shared types and constants for the tree-walk Huffman decoder.
package hftw_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int SYM_W         = 8;
	localparam int IDX_W         = 9;
	localparam int COUNT_W       = 32;
	localparam int BITCNT_W      = 4;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_START  = 2'd1,
		OP_DECODE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		CFG_ROOT  = 1'b0,
		CFG_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BIT,
		ST_CHILD,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic             emit;
		logic             flush;
		logic [SYM_W-1:0] sym;
		logic             done;
	} req_t;

endpackage

>>> rtl/core/hftw_out.sv
// Result holding stage: keeps the newest symbol back until its last-of-byte mark is known.
module hftw_out (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hftw_pkg::req_t            req,
	output logic                      room,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [hftw_pkg::SYM_W-1:0] m_axis_tdata,  // [7:0] symbol
	output logic                      m_axis_tlast,  // last_of_byte
	output logic                      m_axis_tuser   // stream_done
);

	logic                       tvalid_q;
	logic [hftw_pkg::SYM_W-1:0] tdata_q;
	logic                       tlast_q;
	logic                       tuser_q;
	logic                       pend_valid_q;
	logic [hftw_pkg::SYM_W-1:0] pend_sym_q;
	logic                       pend_done_q;

	assign room          = !tvalid_q || m_axis_tready;
	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tlast  = tlast_q;
	assign m_axis_tuser  = tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q     <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (tvalid_q && m_axis_tready) begin
				tvalid_q <= 1'b0;
			end
			if (room && pend_valid_q && (req.emit || req.flush)) begin
				tvalid_q <= 1'b1;
			end
			if (room && req.emit) begin
				pend_valid_q <= 1'b1;
			end else if (room && req.flush) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (room && pend_valid_q && (req.emit || req.flush)) begin
			tdata_q <= pend_sym_q;
			tuser_q <= pend_done_q;
			tlast_q <= !req.emit;
		end
		if (room && req.emit) begin
			pend_sym_q  <= req.sym;
			pend_done_q <= req.done;
		end
	end

endmodule

>>> rtl/core/huffman_tree_walk_decoder_top.sv
// Huffman decoder top level: node store, configuration registers and bit-serial tree walk.
// Node write, start and ignored items are each taken in ST_IDLE.
// A code byte is accepted in ST_IDLE; each bit then takes ST_BIT on a leaf, or ST_BIT and
// ST_CHILD on an inner node (the node store read chained through each walk step); the byte
// closes with a final bit check and a flush, earlier once the count runs out.
// Results of a byte leave with a lag of one symbol, the last one at the close of the byte.
// Reset clears walk position, count, root and control; the node store holds no reset value.
module huffman_tree_walk_decoder_top #(
	parameter int NODE_COUNT = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // node_index, node_is_leaf, left_child, right_child,
	                                   // leaf_symbol, code_byte, 4 zero bits
	input  logic [1:0]  s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // symbol
	output logic        m_axis_tlast,  // last_of_byte
	output logic        m_axis_tuser,  // stream_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW     = $clog2(NODE_COUNT);
	localparam int NODE_W = 1 + 2 * AW + hftw_pkg::SYM_W;

	function automatic logic [AW-1:0] wrap_idx(input logic [hftw_pkg::IDX_W-1:0] v);
		logic [12:0] r;
		r = {4'b0, v};
		for (int k = 8; k >= 0; k--) begin
			if ((NODE_COUNT << k) < 512) begin
				if (r >= 13'(NODE_COUNT << k)) begin
					r = r - 13'(NODE_COUNT << k);
				end
			end
		end
		return AW'(r);
	endfunction

	logic [NODE_W-1:0] mem [NODE_COUNT];
	logic [NODE_W-1:0] rd_q;

	hftw_pkg::state_t state_q, state_d;
	logic [AW-1:0]                     root_q;
	logic [hftw_pkg::COUNT_W-1:0]      count_q;
	logic [AW-1:0]                     walk_q, walk_d;
	logic [hftw_pkg::COUNT_W-1:0]      rem_q, rem_d;
	logic [hftw_pkg::BITS_PER_BYTE-1:0] byte_q, byte_d;
	logic [hftw_pkg::BITCNT_W-1:0]     bitcnt_q, bitcnt_d;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic          accept;
	logic          room;
	hftw_pkg::op_t op;
	hftw_pkg::req_t req;

	logic                        rd_leaf;
	logic [AW-1:0]               rd_left;
	logic [AW-1:0]               rd_right;
	logic [hftw_pkg::SYM_W-1:0]  rd_sym;

	assign op        = hftw_pkg::op_t'(s_axis_tuser);
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	assign rd_leaf  = rd_q[NODE_W-1];
	assign rd_right = rd_q[2*AW+7:AW+8];
	assign rd_left  = rd_q[AW+7:8];
	assign rd_sym   = rd_q[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q  <= '0;
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (hftw_pkg::cfg_reg_t'(cfg_index))
				hftw_pkg::CFG_ROOT:  root_q  <= wrap_idx(cfg_data[8:0]);
				hftw_pkg::CFG_COUNT: count_q <= cfg_data;
				default:             root_q  <= root_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wrap_idx(s_axis_tdata[8:0])] <= {s_axis_tdata[9], wrap_idx(s_axis_tdata[27:19]),
				wrap_idx(s_axis_tdata[18:10]), s_axis_tdata[35:28]};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= hftw_pkg::ST_IDLE;
			walk_q   <= '0;
			rem_q    <= '0;
			byte_q   <= '0;
			bitcnt_q <= '0;
		end else begin
			state_q  <= state_d;
			walk_q   <= walk_d;
			rem_q    <= rem_d;
			byte_q   <= byte_d;
			bitcnt_q <= bitcnt_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		walk_d        = walk_q;
		rem_d         = rem_q;
		byte_d        = byte_q;
		bitcnt_d      = bitcnt_q;
		rd_en         = 1'b0;
		rd_addr       = walk_q;
		wr_en         = 1'b0;
		s_axis_tready = 1'b0;
		req           = '0;
		case (state_q)
			hftw_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					case (op)
						hftw_pkg::OP_WRITE: wr_en = 1'b1;
						hftw_pkg::OP_START: begin
							walk_d = root_q;
							rem_d  = count_q;
						end
						hftw_pkg::OP_DECODE: begin
							rd_en    = 1'b1;
							byte_d   = s_axis_tdata[43:36];
							bitcnt_d = '0;
							state_d  = hftw_pkg::ST_BIT;
						end
						default: state_d = hftw_pkg::ST_IDLE;
					endcase
				end
			end
			hftw_pkg::ST_BIT: begin
				if (rem_q == '0 || bitcnt_q == hftw_pkg::BITCNT_W'(hftw_pkg::BITS_PER_BYTE)) begin
					state_d = hftw_pkg::ST_FLUSH;
				end else if (rd_leaf) begin
					if (room) begin
						req.emit = 1'b1;
						req.sym  = rd_sym;
						req.done = (rem_q == hftw_pkg::COUNT_W'(1));
						rem_d    = rem_q - hftw_pkg::COUNT_W'(1);
						walk_d   = root_q;
						rd_en    = 1'b1;
						rd_addr  = root_q;
						byte_d   = {byte_q[hftw_pkg::BITS_PER_BYTE-2:0], 1'b0};
						bitcnt_d = bitcnt_q + hftw_pkg::BITCNT_W'(1);
					end
				end else begin
					walk_d  = byte_q[hftw_pkg::BITS_PER_BYTE-1] ? rd_right : rd_left;
					rd_en   = 1'b1;
					rd_addr = walk_d;
					byte_d  = {byte_q[hftw_pkg::BITS_PER_BYTE-2:0], 1'b0};
					state_d = hftw_pkg::ST_CHILD;
				end
			end
			hftw_pkg::ST_CHILD: begin
				if (rd_leaf) begin
					if (room) begin
						req.emit = 1'b1;
						req.sym  = rd_sym;
						req.done = (rem_q == hftw_pkg::COUNT_W'(1));
						rem_d    = rem_q - hftw_pkg::COUNT_W'(1);
						walk_d   = root_q;
						rd_en    = 1'b1;
						rd_addr  = root_q;
						bitcnt_d = bitcnt_q + hftw_pkg::BITCNT_W'(1);
						state_d  = hftw_pkg::ST_BIT;
					end
				end else begin
					bitcnt_d = bitcnt_q + hftw_pkg::BITCNT_W'(1);
					state_d  = hftw_pkg::ST_BIT;
				end
			end
			hftw_pkg::ST_FLUSH: begin
				if (room) begin
					req.flush = 1'b1;
					state_d   = hftw_pkg::ST_IDLE;
				end
			end
			default: state_d = hftw_pkg::ST_IDLE;
		endcase
	end

	hftw_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.room          (room),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	a_emit_needs_count: assert property (@(posedge clk) disable iff (!arst_n)
		req.emit |-> rem_q != '0)
		else $error("symbol emitted with no symbols remaining");

	a_emit_returns_root: assert property (@(posedge clk) disable iff (!arst_n)
		req.emit |=> walk_q == $past(root_q))
		else $error("walk did not return to root after a symbol");

	a_bitcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bitcnt_q <= hftw_pkg::BITCNT_W'(hftw_pkg::BITS_PER_BYTE))
		else $error("bit counter ran past one byte");

	a_decode_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == hftw_pkg::OP_DECODE) |=> state_q == hftw_pkg::ST_BIT)
		else $error("code byte accepted without starting the walk");

	a_emit_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.emit || req.flush) |-> !s_axis_tready)
		else $error("result request while taking input");

endmodule

>>> test/testbench.sv
// Self-checking testbench for the tree-walk Huffman decoder: random code trees, streams and bytes.
`timescale 1ns / 100ps

module testbench;

	localparam int STORE_DEPTH  = 512;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int ITEM_TARGET  = 220;
	localparam int CALM_ITEMS   = 180;

	typedef struct packed {
		hftw_pkg::op_t              op;
		logic [hftw_pkg::IDX_W-1:0] node_index;
		logic                       node_is_leaf;
		logic [hftw_pkg::IDX_W-1:0] left_child;
		logic [hftw_pkg::IDX_W-1:0] right_child;
		logic [hftw_pkg::SYM_W-1:0] leaf_symbol;
		logic [hftw_pkg::SYM_W-1:0] code_byte;
	} code_item_t;

	typedef struct packed {
		logic                       leaf;
		logic [hftw_pkg::IDX_W-1:0] left;
		logic [hftw_pkg::IDX_W-1:0] right;
		logic [hftw_pkg::SYM_W-1:0] sym;
	} tree_node_t;

	typedef struct packed {
		logic [hftw_pkg::SYM_W-1:0] symbol;
		logic                       last_of_byte;
		logic                       stream_done;
	} symbol_beat_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata  = '0;  // node_index, node_is_leaf, left_child, right_child,
	                                  // leaf_symbol, code_byte, 4 zero bits
	logic [1:0]  s_axis_tuser  = hftw_pkg::OP_WRITE;  // operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;  // symbol
	logic        m_axis_tlast;
	logic        m_axis_tuser;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index     = hftw_pkg::CFG_ROOT;
	logic [31:0] cfg_data      = '0;

	// decoder mirror
	tree_node_t                   tree_mirror [STORE_DEPTH];
	logic [hftw_pkg::IDX_W-1:0]   walk_pos     = '0;
	logic [hftw_pkg::IDX_W-1:0]   root_mirror  = '0;
	logic [hftw_pkg::COUNT_W-1:0] remaining    = '0;
	logic [hftw_pkg::COUNT_W-1:0] count_mirror = '0;
	symbol_beat_t                 symbol_q [$];
	symbol_beat_t                 want;

	// stimulus state
	code_item_t                 pending_q [$];
	code_item_t                 staged_q [$];
	code_item_t                 cur_item;
	bit                         node_ready [STORE_DEPTH];
	bit                         tree_taken [STORE_DEPTH];
	logic [hftw_pkg::IDX_W-1:0] ready_list [$];
	int                         items_posted = 0;
	int                         items_taken  = 0;
	int                         item_count   = 0;
	int                         errors       = 0;
	int                         cycles       = 0;
	int                         send_gap     = 0;
	int                         stall_gap    = 0;
	bit                         calm         = 1'b0;

	huffman_tree_walk_decoder_top i_dut (.*);

	always #2 clk = ~clk;

	function automatic void walk_code_byte(input logic [hftw_pkg::SYM_W-1:0] code);
		tree_node_t   node;
		symbol_beat_t beat;
		int           produced;
		produced = 0;
		for (int b = 0; b < hftw_pkg::BITS_PER_BYTE; b++) begin
			if (remaining == 0)
				break;
			node = tree_mirror[walk_pos];
			if (!node.leaf) begin
				walk_pos = code[hftw_pkg::BITS_PER_BYTE-1-b] ? node.right : node.left;
				node = tree_mirror[walk_pos];
				if (!node.leaf)
					continue;
			end
			remaining--;
			beat.symbol       = node.sym;
			beat.last_of_byte = 1'b0;
			beat.stream_done  = (remaining == 0);
			symbol_q.push_back(beat);
			produced++;
			walk_pos = root_mirror;
		end
		if (produced > 0) begin
			beat = symbol_q.pop_back();
			beat.last_of_byte = 1'b1;
			symbol_q.push_back(beat);
		end
	endfunction

	function automatic void apply_item(input code_item_t it);
		case (it.op)
			hftw_pkg::OP_WRITE: begin
				tree_mirror[it.node_index] = {it.node_is_leaf, it.left_child, it.right_child,
				                              it.leaf_symbol};
			end
			hftw_pkg::OP_START: begin
				walk_pos  = root_mirror;
				remaining = count_mirror;
			end
			hftw_pkg::OP_DECODE: begin
				walk_code_byte(it.code_byte);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic code_item_t random_item(input hftw_pkg::op_t op);
		code_item_t it;
		it.op           = op;
		it.node_index   = hftw_pkg::IDX_W'($urandom);
		it.node_is_leaf = 1'($urandom);
		it.left_child   = hftw_pkg::IDX_W'($urandom);
		it.right_child  = hftw_pkg::IDX_W'($urandom);
		it.leaf_symbol  = hftw_pkg::SYM_W'($urandom);
		it.code_byte    = hftw_pkg::SYM_W'($urandom);
		return it;
	endfunction

	function automatic code_item_t node_write(input logic [hftw_pkg::IDX_W-1:0] idx,
			input logic leaf, input logic [hftw_pkg::IDX_W-1:0] left,
			input logic [hftw_pkg::IDX_W-1:0] right, input logic [hftw_pkg::SYM_W-1:0] sym);
		code_item_t it;
		it              = random_item(hftw_pkg::OP_WRITE);
		it.node_index   = idx;
		it.node_is_leaf = leaf;
		it.left_child   = left;
		it.right_child  = right;
		it.leaf_symbol  = sym;
		return it;
	endfunction

	function automatic code_item_t code_item(input logic [hftw_pkg::SYM_W-1:0] code);
		code_item_t it;
		it           = random_item(hftw_pkg::OP_DECODE);
		it.code_byte = code;
		return it;
	endfunction

	// inner nodes only point at entries already written
	function automatic code_item_t noise_item();
		code_item_t it;
		it = random_item(hftw_pkg::OP_NONE);
		if ($urandom_range(0, 1) == 0) begin
			it.op = hftw_pkg::OP_WRITE;
			if (!it.node_is_leaf) begin
				it.left_child  = ready_list[$urandom_range(0, ready_list.size() - 1)];
				it.right_child = ready_list[$urandom_range(0, ready_list.size() - 1)];
			end
		end
		return it;
	endfunction

	function automatic void stage(input code_item_t it);
		staged_q.push_back(it);
		if (it.op != hftw_pkg::OP_NONE)
			item_count++;
		if (it.op == hftw_pkg::OP_WRITE && !node_ready[it.node_index]) begin
			node_ready[it.node_index] = 1'b1;
			ready_list.push_back(it.node_index);
		end
	endfunction

	function automatic void release_staged();
		while (staged_q.size() > 0) begin
			pending_q.push_back(staged_q.pop_front());
			items_posted++;
		end
	endfunction

	function automatic logic [hftw_pkg::IDX_W-1:0] fresh_index();
		logic [hftw_pkg::IDX_W-1:0] idx;
		do
			idx = hftw_pkg::IDX_W'($urandom);
		while (tree_taken[idx]);
		tree_taken[idx] = 1'b1;
		return idx;
	endfunction

	// leaves first, then pair random subtrees until one root is left
	task automatic build_tree(input int leaves, output logic [hftw_pkg::IDX_W-1:0] root);
		logic [hftw_pkg::IDX_W-1:0] pool [$];
		logic [hftw_pkg::IDX_W-1:0] kid_a;
		logic [hftw_pkg::IDX_W-1:0] kid_b;
		int                         pick;
		for (int i = 0; i < STORE_DEPTH; i++)
			tree_taken[i] = 1'b0;
		for (int i = 0; i < leaves; i++) begin
			pool.push_back(fresh_index());
			stage(node_write(pool[$], 1'b1, hftw_pkg::IDX_W'($urandom),
			                 hftw_pkg::IDX_W'($urandom), hftw_pkg::SYM_W'($urandom)));
		end
		while (pool.size() > 1) begin
			pick  = $urandom_range(0, pool.size() - 1);
			kid_a = pool[pick];
			pool.delete(pick);
			pick  = $urandom_range(0, pool.size() - 1);
			kid_b = pool[pick];
			pool.delete(pick);
			pool.push_back(fresh_index());
			stage(node_write(pool[$], 1'b0, kid_a, kid_b, hftw_pkg::SYM_W'($urandom)));
		end
		root = pool[0];
	endtask

	task automatic wait_idle();
		while (items_taken != items_posted || symbol_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [hftw_pkg::IDX_W-1:0] root,
			input logic [hftw_pkg::COUNT_W-1:0] count);
		cfg_valid <= 1'b1;
		cfg_index <= hftw_pkg::CFG_ROOT;
		cfg_data  <= {{(hftw_pkg::COUNT_W - hftw_pkg::IDX_W){1'b0}}, root};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		root_mirror = root;
		cfg_index <= hftw_pkg::CFG_COUNT;
		cfg_data  <= count;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		count_mirror = count;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= hftw_pkg::OP_WRITE;
			send_gap = 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				apply_item(cur_item);
				items_taken++;
			end
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(0, 11);
				s_axis_tvalid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				cur_item = pending_q.pop_front();
				s_axis_tdata  <= {4'b0000, cur_item.code_byte, cur_item.leaf_symbol,
				                  cur_item.right_child, cur_item.left_child,
				                  cur_item.node_is_leaf, cur_item.node_index};
				s_axis_tuser  <= cur_item.op;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_gap = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (symbol_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat, expected none, actual symbol %02h",
					         $time, m_axis_tdata);
				end else begin
					want = symbol_q.pop_front();
					if (m_axis_tdata !== want.symbol) begin
						errors++;
						$display("%0t: symbol expected %02h actual %02h",
						         $time, want.symbol, m_axis_tdata);
					end
					if (m_axis_tlast !== want.last_of_byte) begin
						errors++;
						$display("%0t: last_of_byte expected %0b actual %0b",
						         $time, want.last_of_byte, m_axis_tlast);
					end
					if (m_axis_tuser !== want.stream_done) begin
						errors++;
						$display("%0t: stream_done expected %0b actual %0b",
						         $time, want.stream_done, m_axis_tuser);
					end
				end
			end
			if (stall_gap > 0) begin
				stall_gap--;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_gap = $urandom_range(0, 11);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [hftw_pkg::IDX_W-1:0]   root;
		logic [hftw_pkg::COUNT_W-1:0] count;
		logic [hftw_pkg::SYM_W-1:0]   code;
		code_item_t                   junk;
		int                           leaves;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// small hand-built tree rooted at the top entry, with a loop back to the root
		set_config(9'd511, 32'd3);
		stage(code_item(8'hA5));
		stage(node_write(9'd0, 1'b1, 9'd511, 9'd511, 8'hFF));
		stage(node_write(9'd2, 1'b1, 9'd0, 9'd0, 8'h00));
		stage(node_write(9'd1, 1'b0, 9'd2, 9'd511, 8'hA5));
		stage(node_write(9'd511, 1'b0, 9'd0, 9'd1, 8'h5A));
		junk = '1;
		junk.op = hftw_pkg::OP_NONE;
		stage(junk);
		stage(random_item(hftw_pkg::OP_START));
		stage(code_item(8'h00));
		stage(code_item(8'hFF));
		release_staged();
		wait_idle();

		set_config(9'd511, '1);
		stage(random_item(hftw_pkg::OP_START));
		stage(code_item(8'hFF));
		stage(code_item(8'h40));
		release_staged();
		wait_idle();

		// move the root to a leaf mid-stream, then restart on it
		set_config(9'd0, 32'd5);
		stage(code_item(8'hA5));
		stage(random_item(hftw_pkg::OP_START));
		stage(code_item(8'h3C));
		stage(code_item(8'h00));
		release_staged();
		wait_idle();

		set_config(9'd0, 32'd0);
		stage(random_item(hftw_pkg::OP_START));
		stage(code_item(8'hFF));
		release_staged();

		item_count = 0;
		while (item_count < ITEM_TARGET) begin
			wait_idle();
			calm = (item_count >= CALM_ITEMS);
			case ($urandom_range(0, 9))
				0: leaves = 1;
				1: leaves = $urandom_range(16, 40);
				default: leaves = $urandom_range(2, 9);
			endcase
			build_tree(leaves, root);
			case ($urandom_range(0, 19))
				0: count = '0;
				1: count = '1;
				2, 3: count = $urandom;
				4, 5, 6, 7: count = $urandom_range(1, 3);
				default: count = $urandom_range(4, 64);
			endcase
			if ($urandom_range(0, 6) != 0)
				stage(random_item(hftw_pkg::OP_START));
			repeat ($urandom_range(2, 10)) begin
				if ($urandom_range(0, 9) == 0)
					stage(noise_item());
				case ($urandom_range(0, 9))
					0: code = 8'h00;
					1: code = 8'hFF;
					default: code = hftw_pkg::SYM_W'($urandom);
				endcase
				stage(code_item(code));
			end
			set_config(root, count);
			release_staged();
		end
		wait_idle();

		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
